/* rtl/core/hpw_pkg.sv */
// Shared constants and types of the homography point warp block.
package hpw_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int SCALE_FRAC = 16;
  localparam int NUM_COEFS  = 9;
  localparam int COEF_W     = 32;
  localparam int PROD_W     = 2 * COEF_W;
  localparam int SUM_W      = 49;
  localparam int MAG_W      = 48;
  localparam int Q1_W       = 40;
  localparam int Q2_W       = 33;
  localparam int SCALE_W    = 24;
  localparam int W_STEPS    = Q1_W;
  localparam int S_STEPS    = Q2_W;
  localparam int CFG_ADDR_W = 3;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_POINT = 1'b1;

  localparam logic REG_COORD_SCALE = 1'b0;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;
  localparam logic signed [COEF_W-1:0] COEF_ONE = 32'sd1 <<< FRAC_BITS;

  // Projected numerators and divisor after the matrix product
  typedef struct packed {
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
    logic [MAG_W-1:0] w;
    logic             neg_x;
    logic             neg_y;
    logic             ovf_x;
    logic             ovf_y;
    logic             clamped;
  } front_out_t;

  // Quotients by w
  typedef struct packed {
    logic [Q1_W-1:0] q_x;
    logic [Q1_W-1:0] q_y;
    logic            neg_x;
    logic            neg_y;
    logic            ovf_x;
    logic            ovf_y;
    logic            clamped;
  } wdiv_out_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] warped_x;
    logic signed [COEF_W-1:0] warped_y;
    logic                     divisor_clamped;
    logic                     saturated;
  } result_t;

endpackage

/* rtl/core/hpw_if.sv */
// Input and result channel interfaces of the homography point warp block.
interface hpw_in_if;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [3:0]               coef_index;
  logic signed [31:0]       coef_value;
  logic signed [31:0]       point_x;
  logic signed [31:0]       point_y;
  modport source (output valid, kind, coef_index, coef_value, point_x, point_y, input ready);
  modport sink (input valid, kind, coef_index, coef_value, point_x, point_y, output ready);
endinterface

interface hpw_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] warped_x;
  logic signed [31:0] warped_y;
  logic               divisor_clamped;
  logic               saturated;
  modport source (output valid, warped_x, warped_y, divisor_clamped, saturated, input ready);
  modport sink (input valid, warped_x, warped_y, divisor_clamped, saturated, output ready);
endinterface

/* rtl/core/hpw_front.sv */
// Coefficient store, matrix product, divisor clamp and magnitude stage.
module hpw_front (
  input  logic                clk,
  input  logic                rst_n,
  hpw_in_if.sink              in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output hpw_pkg::front_out_t out_data
);

  logic signed [hpw_pkg::COEF_W-1:0] coef_r [hpw_pkg::NUM_COEFS];

  // Rank A: products
  logic                              va_r;
  logic signed [hpw_pkg::PROD_W-1:0] p_r [6];
  logic signed [hpw_pkg::COEF_W-1:0] c_r [3];
  // Rank B: sums
  logic                             vb_r;
  logic signed [hpw_pkg::SUM_W-1:0] xp_r, yp_r, w_r;
  // Rank C
  logic                vc_r;
  hpw_pkg::front_out_t oc_r;

  logic rdy_a, rdy_b, rdy_c;
  logic pt_valid, load_acc;

  assign rdy_c = !vc_r || out_ready;
  assign rdy_b = !vb_r || rdy_c;
  assign rdy_a = !va_r || rdy_b;
  assign in_item.ready = rdy_a;
  assign pt_valid = in_item.valid && (in_item.kind == hpw_pkg::KIND_POINT);
  assign load_acc = in_item.valid && rdy_a && (in_item.kind == hpw_pkg::KIND_LOAD) &&
                    (in_item.coef_index < 4'(hpw_pkg::NUM_COEFS));

  // Store coefficients; reset to identity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < hpw_pkg::NUM_COEFS; i++) begin
        coef_r[i] <= (i % 4 == 0) ? hpw_pkg::COEF_ONE : '0;
      end
    end else if (load_acc) begin
      coef_r[in_item.coef_index] <= in_item.coef_value;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= pt_valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
    end
  end

  // Multiply coefficients by the point
  always_ff @(posedge clk) begin
    if (rdy_a && pt_valid) begin
      for (int r = 0; r < 3; r++) begin
        p_r[2*r]   <= coef_r[3*r] * in_item.point_x;
        p_r[2*r+1] <= coef_r[3*r+1] * in_item.point_y;
        c_r[r]     <= coef_r[3*r+2];
      end
    end
  end

  // Round products down and sum rows
  logic signed [hpw_pkg::PROD_W-1:0] sh [6];
  logic signed [hpw_pkg::SUM_W-1:0]  row [3];
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      sh[i] = p_r[i] >>> hpw_pkg::FRAC_BITS;
    end
    for (int r = 0; r < 3; r++) begin
      row[r] = $signed(sh[2*r][hpw_pkg::SUM_W-1:0]) + $signed(sh[2*r+1][hpw_pkg::SUM_W-1:0])
             + hpw_pkg::SUM_W'(c_r[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b && va_r) begin
      xp_r <= row[0];
      yp_r <= row[1];
      w_r  <= row[2];
    end
  end

  // Clamp w, take magnitudes and flag quotients that cannot fit
  hpw_pkg::front_out_t oc_nxt;
  logic signed [hpw_pkg::SUM_W-1:0] ax, ay;
  always_comb begin
    ax = xp_r[hpw_pkg::SUM_W-1] ? -xp_r : xp_r;
    ay = yp_r[hpw_pkg::SUM_W-1] ? -yp_r : yp_r;
    oc_nxt.neg_x = xp_r[hpw_pkg::SUM_W-1];
    oc_nxt.neg_y = yp_r[hpw_pkg::SUM_W-1];
    oc_nxt.mag_x = ax[hpw_pkg::MAG_W-1:0];
    oc_nxt.mag_y = ay[hpw_pkg::MAG_W-1:0];
    oc_nxt.clamped = (w_r < hpw_pkg::SUM_W'(1));
    oc_nxt.w = oc_nxt.clamped ? hpw_pkg::MAG_W'(1) : w_r[hpw_pkg::MAG_W-1:0];
    oc_nxt.ovf_x = (oc_nxt.mag_x >> (hpw_pkg::Q1_W - hpw_pkg::FRAC_BITS)) >= oc_nxt.w;
    oc_nxt.ovf_y = (oc_nxt.mag_y >> (hpw_pkg::Q1_W - hpw_pkg::FRAC_BITS)) >= oc_nxt.w;
  end

  always_ff @(posedge clk) begin
    if (rdy_c && vb_r) oc_r <= oc_nxt;
  end

  assign out_valid = vc_r;
  assign out_data  = oc_r;

endmodule

/* rtl/core/hpw_wdiv.sv */
// Pipelined restoring divider of both numerators by w, one quotient bit per rank.
module hpw_wdiv (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hpw_pkg::front_out_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hpw_pkg::wdiv_out_t  out_data
);

  localparam int N = hpw_pkg::W_STEPS;

  typedef struct packed {
    logic [hpw_pkg::MAG_W-1:0] rem_x;
    logic [hpw_pkg::MAG_W-1:0] rem_y;
    logic [hpw_pkg::MAG_W-1:0] mag_x;
    logic [hpw_pkg::MAG_W-1:0] mag_y;
    logic [hpw_pkg::MAG_W-1:0] w;
    logic [hpw_pkg::Q1_W-1:0]  q_x;
    logic [hpw_pkg::Q1_W-1:0]  q_y;
    logic                      neg_x;
    logic                      neg_y;
    logic                      ovf_x;
    logic                      ovf_y;
    logic                      clamped;
  } rank_t;

  rank_t cur    [0:N];
  rank_t nxt    [1:N];
  rank_t rank_r [1:N];
  logic  v_r    [1:N];
  logic  vin    [1:N];
  logic  rdy    [1:N+1];

  // Seed the remainder with the numerator bits above the quotient
  always_comb begin
    cur[0].rem_x   = in_data.mag_x >> (hpw_pkg::Q1_W - hpw_pkg::FRAC_BITS);
    cur[0].rem_y   = in_data.mag_y >> (hpw_pkg::Q1_W - hpw_pkg::FRAC_BITS);
    cur[0].mag_x   = in_data.mag_x;
    cur[0].mag_y   = in_data.mag_y;
    cur[0].w       = in_data.w;
    cur[0].q_x     = '0;
    cur[0].q_y     = '0;
    cur[0].neg_x   = in_data.neg_x;
    cur[0].neg_y   = in_data.neg_y;
    cur[0].ovf_x   = in_data.ovf_x;
    cur[0].ovf_y   = in_data.ovf_y;
    cur[0].clamped = in_data.clamped;
  end

  assign rdy[N+1] = out_ready;
  assign in_ready = rdy[1];

  for (genvar k = 1; k <= N; k++) begin : g_rank
    localparam int BI = N - k;
    logic bx, by;
    logic [hpw_pkg::MAG_W:0] tx, ty, wx;
    rank_t p, n;

    if (BI >= hpw_pkg::FRAC_BITS) begin : g_bit
      assign bx = p.mag_x[BI - hpw_pkg::FRAC_BITS];
      assign by = p.mag_y[BI - hpw_pkg::FRAC_BITS];
    end else begin : g_zero
      assign bx = 1'b0;
      assign by = 1'b0;
    end

    if (k == 1) begin : g_first
      assign vin[k] = in_valid;
    end else begin : g_next
      assign vin[k] = v_r[k-1];
    end

    assign p = cur[k-1];
    assign cur[k] = rank_r[k];
    assign rdy[k] = !v_r[k] || rdy[k+1];

    // Shift in one numerator bit, subtract w where it fits
    always_comb begin
      n  = p;
      wx = {1'b0, p.w};
      tx = {p.rem_x, bx};
      ty = {p.rem_y, by};
      if (tx >= wx) begin
        n.rem_x = hpw_pkg::MAG_W'(tx - wx);
        n.q_x   = {p.q_x[hpw_pkg::Q1_W-2:0], 1'b1};
      end else begin
        n.rem_x = tx[hpw_pkg::MAG_W-1:0];
        n.q_x   = {p.q_x[hpw_pkg::Q1_W-2:0], 1'b0};
      end
      if (ty >= wx) begin
        n.rem_y = hpw_pkg::MAG_W'(ty - wx);
        n.q_y   = {p.q_y[hpw_pkg::Q1_W-2:0], 1'b1};
      end else begin
        n.rem_y = ty[hpw_pkg::MAG_W-1:0];
        n.q_y   = {p.q_y[hpw_pkg::Q1_W-2:0], 1'b0};
      end
    end
    assign nxt[k] = n;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= vin[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && vin[k]) rank_r[k] <= nxt[k];
    end
  end

  assign out_valid        = v_r[N];
  assign out_data.q_x     = rank_r[N].q_x;
  assign out_data.q_y     = rank_r[N].q_y;
  assign out_data.neg_x   = rank_r[N].neg_x;
  assign out_data.neg_y   = rank_r[N].neg_y;
  assign out_data.ovf_x   = rank_r[N].ovf_x;
  assign out_data.ovf_y   = rank_r[N].ovf_y;
  assign out_data.clamped = rank_r[N].clamped;

endmodule

/* rtl/core/hpw_sdiv.sv */
// Pipelined divider by the image scale, then sign and saturation into the result register.
module hpw_sdiv (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [hpw_pkg::SCALE_W-1:0] scale,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  hpw_pkg::wdiv_out_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output hpw_pkg::result_t            out_data
);

  localparam int N   = hpw_pkg::S_STEPS;
  localparam int PRE = hpw_pkg::Q2_W - hpw_pkg::SCALE_FRAC;

  typedef struct packed {
    logic [hpw_pkg::SCALE_W-1:0] rem_x;
    logic [hpw_pkg::SCALE_W-1:0] rem_y;
    logic [hpw_pkg::Q1_W-1:0]    src_x;
    logic [hpw_pkg::Q1_W-1:0]    src_y;
    logic [hpw_pkg::Q2_W-1:0]    q_x;
    logic [hpw_pkg::Q2_W-1:0]    q_y;
    logic                        neg_x;
    logic                        neg_y;
    logic                        ovf_x;
    logic                        ovf_y;
    logic                        clamped;
  } rank_t;

  rank_t cur    [0:N];
  rank_t nxt    [1:N];
  rank_t rank_r [1:N];
  logic  v_r    [1:N];
  logic  vin    [1:N];
  logic  rdy    [1:N+1];

  logic                   vo_r;
  hpw_pkg::result_t       res_r;
  logic [hpw_pkg::Q1_W-1:0] hx, hy;

  // Seed remainders; flag quotients of 2^33 or more
  always_comb begin
    hx = in_data.q_x >> PRE;
    hy = in_data.q_y >> PRE;
    cur[0].rem_x   = hpw_pkg::SCALE_W'(hx);
    cur[0].rem_y   = hpw_pkg::SCALE_W'(hy);
    cur[0].src_x   = in_data.q_x;
    cur[0].src_y   = in_data.q_y;
    cur[0].q_x     = '0;
    cur[0].q_y     = '0;
    cur[0].neg_x   = in_data.neg_x;
    cur[0].neg_y   = in_data.neg_y;
    cur[0].ovf_x   = in_data.ovf_x || (hx >= hpw_pkg::Q1_W'(scale));
    cur[0].ovf_y   = in_data.ovf_y || (hy >= hpw_pkg::Q1_W'(scale));
    cur[0].clamped = in_data.clamped;
  end

  assign rdy[N+1] = !vo_r || out_ready;
  assign in_ready = rdy[1];

  for (genvar k = 1; k <= N; k++) begin : g_rank
    localparam int BI = N - k;
    logic bx, by;
    logic [hpw_pkg::SCALE_W:0] tx, ty, sx;
    rank_t p, n;

    if (BI >= hpw_pkg::SCALE_FRAC) begin : g_bit
      assign bx = p.src_x[BI - hpw_pkg::SCALE_FRAC];
      assign by = p.src_y[BI - hpw_pkg::SCALE_FRAC];
    end else begin : g_zero
      assign bx = 1'b0;
      assign by = 1'b0;
    end

    if (k == 1) begin : g_first
      assign vin[k] = in_valid;
    end else begin : g_next
      assign vin[k] = v_r[k-1];
    end

    assign p = cur[k-1];
    assign cur[k] = rank_r[k];
    assign rdy[k] = !v_r[k] || rdy[k+1];

    // Shift in one bit, subtract the scale where it fits
    always_comb begin
      n  = p;
      sx = {1'b0, scale};
      tx = {p.rem_x, bx};
      ty = {p.rem_y, by};
      if (tx >= sx) begin
        n.rem_x = hpw_pkg::SCALE_W'(tx - sx);
        n.q_x   = {p.q_x[hpw_pkg::Q2_W-2:0], 1'b1};
      end else begin
        n.rem_x = tx[hpw_pkg::SCALE_W-1:0];
        n.q_x   = {p.q_x[hpw_pkg::Q2_W-2:0], 1'b0};
      end
      if (ty >= sx) begin
        n.rem_y = hpw_pkg::SCALE_W'(ty - sx);
        n.q_y   = {p.q_y[hpw_pkg::Q2_W-2:0], 1'b1};
      end else begin
        n.rem_y = ty[hpw_pkg::SCALE_W-1:0];
        n.q_y   = {p.q_y[hpw_pkg::Q2_W-2:0], 1'b0};
      end
    end
    assign nxt[k] = n;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= vin[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && vin[k]) rank_r[k] <= nxt[k];
    end
  end

  // Apply sign and saturate to the signed 32-bit range
  hpw_pkg::result_t res_nxt;
  logic sat_x, sat_y;
  rank_t f;
  always_comb begin
    f = rank_r[N];
    if (f.neg_x) begin
      sat_x = f.ovf_x || f.q_x[32] || (f.q_x[31] && (f.q_x[30:0] != '0));
      res_nxt.warped_x = sat_x ? 32'sh8000_0000 : -$signed(f.q_x[31:0]);
    end else begin
      sat_x = f.ovf_x || f.q_x[32] || f.q_x[31];
      res_nxt.warped_x = sat_x ? 32'sh7FFF_FFFF : $signed(f.q_x[31:0]);
    end
    if (f.neg_y) begin
      sat_y = f.ovf_y || f.q_y[32] || (f.q_y[31] && (f.q_y[30:0] != '0));
      res_nxt.warped_y = sat_y ? 32'sh8000_0000 : -$signed(f.q_y[31:0]);
    end else begin
      sat_y = f.ovf_y || f.q_y[32] || f.q_y[31];
      res_nxt.warped_y = sat_y ? 32'sh7FFF_FFFF : $signed(f.q_y[31:0]);
    end
    res_nxt.divisor_clamped = f.clamped;
    res_nxt.saturated       = sat_x || sat_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (rdy[N+1]) begin
      vo_r <= v_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[N+1] && v_r[N]) res_r <= res_nxt;
  end

  assign out_valid = vo_r;
  assign out_data  = res_r;

endmodule

/* rtl/core/homography_point_warp.sv */
// Top level of the homography point warp block: config port and pipeline.
//
// in_item carries load items (kind 0: write coefficient coef_index, row-major,
// Q16.16) and point items (kind 1: point_x, point_y in Q16.16). A load takes
// effect at its acceptance and yields no result; indexes above eight are dropped.
// Each point yields one item on out_item: the point mapped through the stored
// 3x3 matrix, divided by w (raised to one LSB if smaller) and by coord_scale,
// saturated to 32 bits, with the divisor_clamped and saturated flags.
// Throughput: one item per cycle while the receiver does not stall. There are
// 77 register ranks from input to result: three ranks of multiply, sum and
// clamp, 40 ranks of the divider by w (one quotient bit each), 33 ranks of
// the divider by the scale and one result register.
// cfg_*: APB write of coord_scale (unsigned Q8.16) at byte address 0, to be
// done while no point is in flight; a scale of zero acts as one LSB.
// Reset (rst_n low, synchronous) empties the pipeline, loads the identity
// matrix and sets coord_scale to 1.0. When the receiver stalls, items pack
// into empty ranks; in_item.ready drops only once every rank is full.
module homography_point_warp (
  input  logic                           clk,
  input  logic                           rst_n,
  hpw_in_if.sink                         in_item,
  hpw_out_if.source                      out_item,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [hpw_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);

  logic [hpw_pkg::SCALE_W-1:0] scale_r;
  logic [hpw_pkg::SCALE_W-1:0] scale_eff;

  // Configuration register
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= hpw_pkg::SCALE_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 (cfg_paddr[2] == hpw_pkg::REG_COORD_SCALE)) begin
      scale_r <= cfg_pwdata[hpw_pkg::SCALE_W-1:0];
    end
  end
  assign cfg_prdata = (cfg_paddr[2] == hpw_pkg::REG_COORD_SCALE) ? 32'(scale_r) : '0;
  assign scale_eff  = (scale_r == '0) ? hpw_pkg::SCALE_W'(1) : scale_r;

  logic                fr_valid, fr_ready;
  hpw_pkg::front_out_t fr_data;
  logic                wd_valid, wd_ready;
  hpw_pkg::wdiv_out_t  wd_data;
  hpw_pkg::result_t    res;

  hpw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_data  (fr_data)
  );

  hpw_wdiv u_wdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_data   (fr_data),
    .out_valid (wd_valid),
    .out_ready (wd_ready),
    .out_data  (wd_data)
  );

  hpw_sdiv u_sdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .scale     (scale_eff),
    .in_valid  (wd_valid),
    .in_ready  (wd_ready),
    .in_data   (wd_data),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .out_data  (res)
  );

  assign out_item.warped_x        = res.warped_x;
  assign out_item.warped_y        = res.warped_y;
  assign out_item.divisor_clamped = res.divisor_clamped;
  assign out_item.saturated       = res.saturated;

endmodule

/* rtl/core/hpw_checker.sv */
// Port-level assertions for the homography point warp block, bound to the top level.
module hpw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] warped_x,
  input logic [31:0] warped_y,
  input logic        saturated,
  input logic        cfg_pready
);

  // Result is held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(warped_x) && $stable(warped_y))
    else $error("result changed while stalled");

  // Saturation shows a limit value on at least one coordinate
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && saturated |->
      (warped_x == 32'h7FFF_FFFF) || (warped_x == 32'h8000_0000) ||
      (warped_y == 32'h7FFF_FFFF) || (warped_y == 32'h8000_0000))
    else $error("saturated flag without limit value");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Config port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("cfg_pready low");

endmodule

bind homography_point_warp hpw_checker u_hpw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_item.valid),
  .out_ready  (out_item.ready),
  .warped_x   (out_item.warped_x),
  .warped_y   (out_item.warped_y),
  .saturated  (out_item.saturated),
  .cfg_pready (cfg_pready)
);
